// ===== hdl/rsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine package
// Shared types and register indexes of the rope spring force engine.
// ----------------------------------------------------------------------------
package rsfe_pkg;

	localparam int CW = 32;

	localparam logic [2:0] CFG_STIFFNESS = 3'd0;
	localparam logic [2:0] CFG_DAMPING   = 3'd1;
	localparam logic [2:0] CFG_STRETCH   = 3'd2;
	localparam logic [2:0] CFG_BEND      = 3'd3;
	localparam logic [2:0] CFG_CAPTURE   = 3'd4;

	typedef struct packed {
		logic [CW-1:0] ke;
		logic [CW-1:0] kd;
		logic          stretch_on;
		logic          bend_on;
		logic          capture;
	} cfg_t;

	typedef struct packed {
		logic [2:0][CW-1:0] pos;
		logic [2:0][CW-1:0] vel;
		logic               last;
		logic               has1;
		logic               has2;
	} item_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} bk_stat_t;

endpackage

// ===== hdl/rope_spring_force_engine.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine
// Stretch and bend spring-damper forces along a chain of particles.
// ----------------------------------------------------------------------------
// Particles enter one word at a time and wait in a two-entry queue while the
// back end works. Each enabled spring of a particle in force mode runs the
// 32-step square root, three 17-step divisions for the unit vector and its
// products on the single shared multiplier, and each result word waits while
// the force stream is not ready. In capture mode each rest length comes from
// the square root alone, with no division. Rest lengths are kept in two
// memories of MAX_PARTICLES entries that hold no value until a capture pass
// has written them.
module rope_spring_force_engine import rsfe_pkg::*; #(
	parameter int MAX_PARTICLES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic         s_tlast,   // last_particle
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // force_x, force_y, force_z
	output logic         m_tlast,   // chain_end
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int AW = $clog2(MAX_PARTICLES);

	cfg_t          cfg_q;
	logic          q_valid;
	item_t         q_item;
	logic [AW-1:0] q_k;
	bk_stat_t      bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STIFFNESS: cfg_q.ke         <= cfg_data;
				CFG_DAMPING:   cfg_q.kd         <= cfg_data;
				CFG_STRETCH:   cfg_q.stretch_on <= cfg_data[0];
				CFG_BEND:      cfg_q.bend_on    <= cfg_data[0];
				CFG_CAPTURE:   cfg_q.capture    <= cfg_data[0];
				default:       cfg_q            <= cfg_q;
			endcase
		end
	end

	rsfe_front #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_k      (q_k),
		.bstat    (bstat)
	);

	rsfe_back #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_k       (q_k),
		.stat      (bstat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_force (m_tdata),
		.out_end   (m_tlast)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |=> !bstat.idle)
		else $error("back end stayed idle after taking a word");

endmodule

// ===== hdl/rsfe_isqrt.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine square root
// Bit-pair iterative integer square root of a 64-bit value, 32 steps.
// ----------------------------------------------------------------------------
module rsfe_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [32:0] root
);

	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] b_q;
	logic [63:0] trial;
	logic        busy_q;
	logic        done_q;

	assign trial = r_q + b_q;
	assign done  = done_q;
	assign root  = r_q[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= n;
				r_q    <= '0;
				b_q    <= 64'h4000_0000_0000_0000;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
				if (b_q == 64'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/rsfe_div.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine divider
// Restoring divider for a quotient known to stay below 2^17, one bit a cycle.
// ----------------------------------------------------------------------------
module rsfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [16:0] quo
);

	logic [47:0] rem_q;
	logic [48:0] dsh_q;
	logic [16:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        fit;

	assign fit  = {1'b0, rem_q} >= dsh_q;
	assign done = done_q;
	assign quo  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				dsh_q  <= {den, 16'h0000};
				q_q    <= '0;
				cnt_q  <= 5'd16;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fit) begin
					rem_q <= rem_q - dsh_q[47:0];
				end
				q_q   <= {q_q[15:0], fit};
				dsh_q <= dsh_q >> 1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

endmodule

// ===== hdl/rsfe_front.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine front end
// Accepts particle words, tags them with their chain index and keeps them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rsfe_front import rsfe_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	localparam int AW = $clog2(MAX_PARTICLES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [191:0]  s_tdata,
	input  logic          s_tlast,
	output logic          q_valid,
	output item_t         q_item,
	output logic [AW-1:0] q_k,
	input  bk_stat_t      bstat
);

	item_t         fifo_q [2];
	logic [AW-1:0] fk_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic [AW-1:0] k_q;
	logic          push;
	item_t         entry;

	assign s_tready = cnt_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = fifo_q[rd_q];
	assign q_k      = fk_q[rd_q];

	always_comb begin
		entry.pos  = s_tdata[95:0];
		entry.vel  = s_tdata[191:96];
		entry.last = s_tlast;
		entry.has1 = k_q != '0;
		entry.has2 = k_q > AW'(1);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= entry;
			fk_q[wr_q]   <= k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
			k_q   <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
				if (s_tlast) begin
					k_q <= '0;
				end else if (k_q != AW'(MAX_PARTICLES - 1)) begin
					k_q <= k_q + AW'(1);
				end
			end
			if (bstat.pop) begin
				rd_q <= !rd_q;
			end
			if (push && !bstat.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && bstat.pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/rsfe_back.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine back end
// Sequences the springs of one particle over a shared multiplier, square root
// and divider, keeps the window and pending forces, and emits result words.
// ----------------------------------------------------------------------------
module rsfe_back import rsfe_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	localparam int AW = $clog2(MAX_PARTICLES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  item_t              q_item,
	input  logic [AW-1:0]      q_k,
	output bk_stat_t           stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0][CW-1:0] out_force,
	output logic               out_end
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PICK, ST_DIFF, ST_SQ, ST_SQRT, ST_CAPW, ST_DIVGO, ST_DIVW,
		ST_DOT, ST_SCALE, ST_FORCE, ST_EMIT, ST_UPD
	} state_t;

	state_t               st_q;
	logic [1:0]           phase_q;
	logic [1:0]           cnt_q;
	logic [1:0]           e_q;
	logic                 sel_q;
	item_t                item_q;
	logic [AW-1:0]        k_q;
	logic signed [31:0]   wp_q [2][3];
	logic signed [31:0]   wv_q [2][3];
	logic signed [31:0]   pf_q [3][3];
	logic signed [31:0]   d_q [3];
	logic signed [31:0]   dv_q [3];
	logic signed [17:0]   u_q [3];
	logic [63:0]          sq_acc_q;
	logic signed [51:0]   dot_acc_q;
	logic signed [35:0]   dot_q;
	logic [32:0]          len_q;
	logic signed [31:0]   tke_q;
	logic signed [31:0]   s_q;
	logic                 ov_q;
	logic [2:0][CW-1:0]   of_q;
	logic                 oe_q;
	logic [65:0]          mul_q;
	logic                 msign_q;
	logic [32:0]          ma;
	logic [32:0]          mb;
	logic                 msgn;
	logic [1:0]           ci;
	logic [1:0]           fc;
	logic signed [31:0]   pa [3];
	logic signed [31:0]   va [3];
	logic [31:0]          smem [MAX_PARTICLES];
	logic [31:0]          bmem [MAX_PARTICLES];
	logic [31:0]          rest_s_q;
	logic [31:0]          rest_b_q;
	logic [31:0]          rest;
	logic [AW-1:0]        addr_s;
	logic [AW-1:0]        addr_b;
	logic                 mem_we;
	logic signed [35:0]   rest_diff;
	logic                 sq_start;
	logic                 sq_done;
	logic [32:0]          sq_root;
	logic [63:0]          sq_n;
	logic                 dv_start;
	logic                 dv_done;
	logic [16:0]          dv_quo;
	logic [47:0]          dv_num;
	logic signed [17:0]   q18;
	logic signed [51:0]   sp;
	logic signed [51:0]   dsum;
	logic signed [31:0]   f_val;
	logic                 do_b;
	logic                 do_s;
	logic                 e_need;
	logic                 slot;
	logic                 emit_go;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		logic [31:0] m;
		m = x[31] ? 32'(-x) : 32'(x);
		return m;
	endfunction

	function automatic logic [16:0] mag18(input logic signed [17:0] x);
		logic [17:0] m;
		m = x[17] ? 18'(-x) : 18'(x);
		return m[16:0];
	endfunction

	function automatic logic signed [31:0] sat51(input logic signed [50:0] x);
		logic signed [31:0] r;
		if (x > 51'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -51'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sres(input logic [65:0] p, input logic neg);
		logic signed [50:0] x;
		x = $signed({1'b0, p[65:16]});
		return sat51(neg ? -x : x);
	endfunction

	function automatic logic [32:0] clampmag(input logic signed [35:0] v);
		logic [35:0] m;
		m = v[35] ? 36'(-v) : 36'(v);
		return (m > 36'h1_0000_0000) ? 33'h1_0000_0000 : m[32:0];
	endfunction

	function automatic logic signed [35:0] trunc16(input logic signed [51:0] x);
		logic [51:0] m;
		logic signed [35:0] h;
		m = x[51] ? 52'(-x) : 52'(x);
		h = $signed(m[51:16]);
		return x[51] ? -h : h;
	endfunction

	rsfe_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n),
		.done   (sq_done),
		.root   (sq_root)
	);

	rsfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (len_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	assign stat      = '{idle: (st_q == ST_IDLE), pop: (st_q == ST_IDLE) && q_valid};
	assign out_valid = ov_q;
	assign out_force = of_q;
	assign out_end   = oe_q;

	assign ci        = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
	assign fc        = cnt_q - 2'd1;
	assign addr_s    = k_q - AW'(1);
	assign addr_b    = k_q - AW'(2);
	assign rest      = sel_q ? rest_b_q : rest_s_q;
	assign rest_diff = $signed({3'b000, len_q}) - $signed({4'h0, rest});
	assign mem_we    = st_q == ST_CAPW;
	assign sq_n      = sq_acc_q + mul_q[63:0];
	assign sq_start  = (st_q == ST_SQ) && (cnt_q == 2'd3);
	assign dv_start  = (st_q == ST_DIVGO) && (len_q != '0);
	assign dv_num    = {mag32(d_q[ci]), 16'h0000};
	assign q18       = $signed({1'b0, dv_quo});
	assign sp        = msign_q ? -$signed({1'b0, mul_q[50:0]}) : $signed({1'b0, mul_q[50:0]});
	assign dsum      = dot_acc_q + sp;
	assign f_val     = sres(mul_q, msign_q);
	assign do_b      = item_q.has2 && (cfg.capture || cfg.bend_on);
	assign do_s      = item_q.has1 && (cfg.capture || cfg.stretch_on);
	assign slot      = !ov_q || out_ready;
	assign emit_go   = (st_q == ST_EMIT) && e_need && slot;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pa[c] = sel_q ? wp_q[0][c] : wp_q[1][c];
			va[c] = sel_q ? wv_q[0][c] : wv_q[1][c];
		end
	end

	always_comb begin
		case (e_q)
			2'd0:    e_need = item_q.has2;
			2'd1:    e_need = item_q.last && item_q.has1;
			default: e_need = item_q.last;
		endcase
	end

	always_comb begin
		ma   = '0;
		mb   = '0;
		msgn = 1'b0;
		case (st_q)
			ST_SQ: begin
				ma = {1'b0, mag32(d_q[ci])};
				mb = {1'b0, mag32(d_q[ci])};
			end
			ST_DOT: begin
				ma   = {1'b0, mag32(dv_q[ci])};
				mb   = {16'h0000, mag18(u_q[ci])};
				msgn = dv_q[ci][31] ^ u_q[ci][17];
			end
			ST_SCALE: begin
				if (cnt_q == 2'd0) begin
					ma   = {1'b0, cfg.ke};
					mb   = clampmag(rest_diff);
					msgn = rest_diff[35];
				end else begin
					ma   = {1'b0, cfg.kd};
					mb   = clampmag(dot_q);
					msgn = dot_q[35];
				end
			end
			ST_FORCE: begin
				ma   = {16'h0000, mag18(u_q[ci])};
				mb   = {1'b0, mag32(s_q)};
				msgn = u_q[ci][17] ^ s_q[31];
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q   <= ma * mb;
		msign_q <= msgn;
	end

	always_ff @(posedge clk) begin
		if (mem_we && sel_q) begin
			bmem[addr_b] <= len_q[31:0];
		end
		if (mem_we && !sel_q) begin
			smem[addr_s] <= len_q[31:0];
		end
		rest_s_q <= smem[addr_s];
		rest_b_q <= bmem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			e_q     <= '0;
			sel_q   <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				for (int c = 0; c < 3; c++) begin
					wp_q[i][c] <= '0;
					wv_q[i][c] <= '0;
				end
			end
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					pf_q[i][c] <= '0;
				end
			end
		end else begin
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						k_q     <= q_k;
						phase_q <= 2'd0;
						st_q    <= ST_PICK;
					end
				end
				ST_PICK: begin
					case (phase_q)
						2'd0: begin
							phase_q <= 2'd1;
							if (do_b) begin
								sel_q <= 1'b1;
								st_q  <= ST_DIFF;
							end
						end
						2'd1: begin
							phase_q <= 2'd2;
							if (do_s) begin
								sel_q <= 1'b0;
								st_q  <= ST_DIFF;
							end
						end
						default: begin
							e_q  <= 2'd0;
							st_q <= cfg.capture ? ST_UPD : ST_EMIT;
						end
					endcase
				end
				ST_DIFF: begin
					for (int c = 0; c < 3; c++) begin
						d_q[c]  <= sat51(51'($signed(item_q.pos[c])) - 51'(pa[c]));
						dv_q[c] <= sat51(51'($signed(item_q.vel[c])) - 51'(va[c]));
					end
					cnt_q    <= 2'd0;
					sq_acc_q <= '0;
					st_q     <= ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q != 2'd0) begin
						sq_acc_q <= sq_n;
					end
					if (cnt_q == 2'd3) begin
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						len_q <= sq_root;
						cnt_q <= 2'd0;
						st_q  <= cfg.capture ? ST_CAPW : ST_DIVGO;
					end
				end
				ST_CAPW: begin
					st_q <= ST_PICK;
				end
				ST_DIVGO: begin
					if (len_q == '0) begin
						for (int c = 0; c < 3; c++) begin
							u_q[c] <= '0;
						end
						cnt_q     <= 2'd0;
						dot_acc_q <= '0;
						st_q      <= ST_DOT;
					end else begin
						st_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (dv_done) begin
						u_q[ci] <= d_q[ci][31] ? -q18 : q18;
						if (cnt_q == 2'd2) begin
							cnt_q     <= 2'd0;
							dot_acc_q <= '0;
							st_q      <= ST_DOT;
						end else begin
							cnt_q <= cnt_q + 2'd1;
							st_q  <= ST_DIVGO;
						end
					end
				end
				ST_DOT: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q != 2'd0) begin
						dot_acc_q <= dsum;
					end
					if (cnt_q == 2'd3) begin
						dot_q <= trunc16(dsum);
						cnt_q <= 2'd0;
						st_q  <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd1) begin
						tke_q <= sres(mul_q, msign_q);
					end
					if (cnt_q == 2'd2) begin
						s_q   <= sat51(51'(tke_q) + 51'(sres(mul_q, msign_q)));
						cnt_q <= 2'd0;
						st_q  <= ST_FORCE;
					end
				end
				ST_FORCE: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q != 2'd0) begin
						if (sel_q) begin
							pf_q[0][fc] <= sat51(51'(pf_q[0][fc]) + 51'(f_val));
						end else begin
							pf_q[1][fc] <= sat51(51'(pf_q[1][fc]) + 51'(f_val));
						end
						pf_q[2][fc] <= sat51(51'(pf_q[2][fc]) - 51'(f_val));
					end
					if (cnt_q == 2'd3) begin
						st_q <= ST_PICK;
					end
				end
				ST_EMIT: begin
					if (!e_need || slot) begin
						if (e_need) begin
							for (int c = 0; c < 3; c++) begin
								of_q[c] <= pf_q[e_q][c];
							end
							oe_q <= e_q == 2'd2;
						end
						if (e_q == 2'd2) begin
							st_q <= ST_UPD;
						end else begin
							e_q <= e_q + 2'd1;
						end
					end
				end
				ST_UPD: begin
					for (int c = 0; c < 3; c++) begin
						if (item_q.last) begin
							wp_q[0][c] <= '0;
							wp_q[1][c] <= '0;
							wv_q[0][c] <= '0;
							wv_q[1][c] <= '0;
						end else begin
							wp_q[0][c] <= wp_q[1][c];
							wv_q[0][c] <= wv_q[1][c];
							wp_q[1][c] <= $signed(item_q.pos[c]);
							wv_q[1][c] <= $signed(item_q.vel[c]);
						end
						if (item_q.last || cfg.capture) begin
							pf_q[0][c] <= '0;
							pf_q[1][c] <= '0;
						end else begin
							pf_q[0][c] <= pf_q[1][c];
							pf_q[1][c] <= pf_q[2][c];
						end
						pf_q[2][c] <= '0;
					end
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/rope_spring_force_engine_check.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine checker
// Watches the input, configuration and force channels of the engine. It keeps
// its own copy of the chain window, pending forces, rest lengths and register
// settings, predicts the force words of every accepted particle and compares
// each accepted force word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rope_spring_force_engine_check import rsfe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic         s_tlast,   // last_particle
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,   // force_x, force_y, force_z
	input  logic         m_tlast,   // chain_end
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending
);

	localparam int     MAXP = 64;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	logic [31:0] ke, kd;
	logic        stretch_en, bend_en, capture_en;
	longint      wpos [2][3];
	longint      wvel [2][3];
	longint      pend [3][3];
	longint      cur_p [3];
	longint      cur_v [3];
	longint      dd [3];
	logic [31:0] stretch_rest [MAXP];
	logic [31:0] bend_rest [MAXP];
	int          kidx;
	logic [96:0] force_queue [$];

	function automatic longint sat32(input longint x);
		return x > SMAX ? SMAX : (x < SMIN ? SMIN : x);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned len_to(input int src);
		longint unsigned sum, m;
		longint t;
		sum = 0;
		for (int c = 0; c < 3; c++) begin
			t = sat32(cur_p[c] - wpos[src][c]);
			m = t < 0 ? -t : t;
			dd[c] = t;
			sum = sum + m * m;
		end
		return int_sqrt(sum);
	endfunction

	function automatic longint scale(input logic [31:0] k, input longint v);
		longint unsigned m, p;
		if (v > 64'sd4294967296) v = 64'sd4294967296;
		if (v < -64'sd4294967296) v = -64'sd4294967296;
		m = v < 0 ? -v : v;
		p = (longint'(k) * m) >> 16;
		return sat32(v < 0 ? -longint'(p) : longint'(p));
	endfunction

	task automatic add_spring(input int src, input logic [31:0] rest);
		longint len, dot, s, f;
		longint u [3];
		len = longint'(len_to(src));
		dot = 0;
		for (int c = 0; c < 3; c++)
			u[c] = (len != 0) ? (dd[c] * 65536) / len : 0;
		for (int c = 0; c < 3; c++)
			dot = dot + sat32(cur_v[c] - wvel[src][c]) * u[c];
		dot = dot / 65536;
		s = sat32(scale(ke, len - longint'(rest)) + scale(kd, dot));
		for (int c = 0; c < 3; c++) begin
			f = sat32((u[c] * s) / 65536);
			pend[src][c] = sat32(pend[src][c] + f);
			pend[2][c] = sat32(pend[2][c] - f);
		end
	endtask

	task automatic push_force(input int slot, input logic chain_end);
		force_queue.push_back({chain_end, pend[slot][2][31:0], pend[slot][1][31:0],
			pend[slot][0][31:0]});
	endtask

	task automatic apply_particle(input logic [191:0] data, input logic last);
		for (int c = 0; c < 3; c++) begin
			cur_p[c] = $signed(data[c*32 +: 32]);
			cur_v[c] = $signed(data[(c+3)*32 +: 32]);
		end
		if (capture_en) begin
			if (kidx >= 1) stretch_rest[(kidx-1) % MAXP] = 32'(len_to(1));
			if (kidx >= 2) bend_rest[(kidx-2) % MAXP] = 32'(len_to(0));
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < 3; c++) pend[i][c] = 0;
		end else begin
			for (int c = 0; c < 3; c++) pend[2][c] = 0;
			if (kidx >= 2 && bend_en) add_spring(0, bend_rest[(kidx-2) % MAXP]);
			if (kidx >= 1 && stretch_en) add_spring(1, stretch_rest[(kidx-1) % MAXP]);
			if (kidx >= 2) push_force(0, 1'b0);
			if (last) begin
				if (kidx >= 1) push_force(1, 1'b0);
				push_force(2, 1'b1);
			end
		end
		if (last) begin
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < 3; c++) begin
					pend[i][c] = 0;
					if (i < 2) begin
						wpos[i][c] = 0;
						wvel[i][c] = 0;
					end
				end
			kidx = 0;
		end else begin
			for (int c = 0; c < 3; c++) begin
				wpos[0][c] = wpos[1][c];
				wvel[0][c] = wvel[1][c];
				wpos[1][c] = cur_p[c];
				wvel[1][c] = cur_v[c];
				pend[0][c] = pend[1][c];
				pend[1][c] = pend[2][c];
				pend[2][c] = 0;
			end
			kidx = (kidx + 1 < MAXP) ? kidx + 1 : MAXP - 1;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		ke = 0;
		kd = 0;
		stretch_en = 0;
		bend_en = 0;
		capture_en = 0;
		kidx = 0;
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 3; c++) begin
				pend[i][c] = 0;
				if (i < 2) begin
					wpos[i][c] = 0;
					wvel[i][c] = 0;
				end
			end
	end

	always @(posedge clk) begin
		logic [96:0] exp_word;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STIFFNESS: ke = cfg_data;
					CFG_DAMPING:   kd = cfg_data;
					CFG_STRETCH:   stretch_en = cfg_data[0];
					CFG_BEND:      bend_en = cfg_data[0];
					CFG_CAPTURE:   capture_en = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_particle(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (force_queue.size() == 0) begin
					$display("%0t: unexpected force word %h last %b", $time, m_tdata, m_tlast);
					errors = errors + 1;
				end else begin
					exp_word = force_queue.pop_front();
					for (int c = 0; c < 3; c++)
						if (exp_word[c*32 +: 32] !== m_tdata[c*32 +: 32]) begin
							$display("%0t: force %0d expected %h actual %h", $time, c,
								exp_word[c*32 +: 32], m_tdata[c*32 +: 32]);
							errors = errors + 1;
						end
					if (exp_word[96] !== m_tlast) begin
						$display("%0t: chain_end expected %b actual %b", $time,
							exp_word[96], m_tlast);
						errors = errors + 1;
					end
				end
			end
			pending = force_queue.size();
		end
	end

endmodule

// ===== bench/rope_spring_force_engine_test.sv =====
// ----------------------------------------------------------------------------
// Rope spring force engine testbench
// Captures rest lengths over a chain longer than the memories, runs directed
// chains with extreme values, zero-length springs and every spring setting,
// then random chains under changing coefficients with random stalls on both
// streams. A checker beside the engine predicts and compares every word.
// ----------------------------------------------------------------------------
module rope_spring_force_engine_test import rsfe_pkg::*; ();

	localparam logic [2:0] CFG_UNUSED = 3'd5;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	logic         s_tlast;   // last_particle
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;   // force_x, force_y, force_z
	logic         m_tlast;   // chain_end
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           errors;
	int           pending;
	logic         calm;
	int           sent;
	int           hold;

	rope_spring_force_engine uut (.*);

	rope_spring_force_engine_check checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		m_tready = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready = 1;
			end else if (hold > 0) begin
				hold = hold - 1;
				m_tready = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				m_tready = 0;
			end else begin
				m_tready = 1;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 19))
			12, 13, 14, 15: return $urandom;
			16: return 32'h7fffffff;
			17: return 32'h80000000;
			18: return 32'h0;
			default: return $urandom_range(0, 32'h001fffff) - 32'h00100000;
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return 32'h00010000;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0003ffff);
		endcase
	endfunction

	task automatic send_word(input logic [191:0] data, input logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 18)) begin
				@(negedge clk);
				s_tvalid = 0;
			end
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tdata = data;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		sent = sent + 1;
	endtask

	task automatic send_particle(input logic last);
		logic [191:0] data;
		for (int c = 0; c < 6; c++) data[c*32 +: 32] = rand_coord();
		send_word(data, last);
	endtask

	task automatic send_chain(input int len);
		for (int i = 0; i < len; i++) send_particle(i == len - 1);
	endtask

	task automatic send_flat(input logic [31:0] pv, input logic [31:0] vv, input logic last);
		send_word({vv, vv, vv, pv, pv, pv}, last);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (pending != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_springs(input logic [31:0] k_e, input logic [31:0] k_d,
			input logic st, input logic bd);
		write_reg(CFG_STIFFNESS, k_e);
		write_reg(CFG_DAMPING, k_d);
		write_reg(CFG_STRETCH, {31'd0, st});
		write_reg(CFG_BEND, {31'd0, bd});
	endtask

	task automatic capture_chain(input int len);
		write_reg(CFG_CAPTURE, 32'd1);
		send_chain(len);
		drain();
		write_reg(CFG_CAPTURE, 32'd0);
	endtask

	initial begin
		int left;
		arst_n = 0;
		calm = 0;
		sent = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		cfg_valid = 0;
		cfg_index = CFG_STIFFNESS;
		cfg_data = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (1200) @(posedge clk);

		// A chain longer than the memories fills every reachable rest slot.
		capture_chain(70);

		set_springs(32'h00010000, 32'h00008000, 1'b1, 1'b1);
		write_reg(CFG_UNUSED, 32'hffffffff);
		send_chain(1);
		send_chain(2);
		send_flat(32'h00010000, 32'h0, 1'b0);
		send_flat(32'h00010000, 32'h00020000, 1'b0);
		send_flat(32'h00030000, 32'h0, 1'b1);
		send_flat(32'h7fffffff, 32'h80000000, 1'b0);
		send_flat(32'h80000000, 32'h7fffffff, 1'b0);
		send_flat(32'h7fffffff, 32'h80000000, 1'b0);
		send_flat(32'h0, 32'hffffffff, 1'b1);
		drain();
		set_springs(32'hffffffff, 32'hffffffff, 1'b1, 1'b1);
		send_flat(32'h80000000, 32'h7fffffff, 1'b0);
		send_flat(32'h7fffffff, 32'h80000000, 1'b0);
		send_chain(3);
		drain();
		set_springs(32'h00020000, 32'h00010000, 1'b1, 1'b0);
		send_chain(3);
		drain();
		set_springs(32'h00020000, 32'h00010000, 1'b0, 1'b1);
		send_chain(3);
		drain();
		set_springs(32'h00020000, 32'h00010000, 1'b0, 1'b0);
		send_chain(3);
		drain();

		while (sent < 430) begin
			if (sent > 370) calm = 1;
			set_springs(rand_coef(), rand_coef(), $urandom_range(0, 3) != 0,
				$urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0) capture_chain($urandom_range(1, 12));
			left = $urandom_range(20, 45);
			while (left > 0) begin
				int len;
				len = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(1, 12);
				send_chain(len);
				left = left - len;
			end
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rsfe_pkg.sv
hdl/rsfe_isqrt.sv
hdl/rsfe_div.sv
hdl/rsfe_front.sv
hdl/rsfe_back.sv
hdl/rope_spring_force_engine.sv
bench/rope_spring_force_engine_check.sv
bench/rope_spring_force_engine_test.sv
